// ===== rtl/fpsf_pkg.sv =====
// shared constants, types and helpers for the five-point stencil filter
package fpsf_pkg;

   // frame geometry and number formats
   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int PIXEL_BITS     = 16;
   localparam int COEF_FRAC_BITS = 14;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);

   // fixed field widths of the ports
   localparam int SIZE_BITS      = 11;
   localparam int COEF_BITS      = 16;
   localparam int VALUE_BITS     = 16;
   localparam int OUT_ROW_BITS   = 10;
   localparam int OUT_COL_BITS   = 10;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // one row store word holds {upper, middle} of a column
   localparam int ROW_WORD_BITS = 2 * PIXEL_BITS;

   // arithmetic widths
   localparam int NSUM_BITS   = PIXEL_BITS + 2;
   localparam int PROD_C_BITS = COEF_BITS + PIXEL_BITS + 1;
   localparam int PROD_N_BITS = COEF_BITS + NSUM_BITS + 1;
   localparam int ACC_BITS    = PROD_N_BITS + 1;
   localparam int QUOT_BITS   = ACC_BITS - 1 - COEF_FRAC_BITS;

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(2 ** (COEF_FRAC_BITS - 1));

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH     = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT    = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CENTER_WEIGHT   = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEIGHBOR_WEIGHT = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_VALUE       = CSR_INDEX_BITS'(4);

   // register reset values
   localparam logic [SIZE_BITS-1:0]         RESET_FRAME_WIDTH     = SIZE_BITS'(1024);
   localparam logic [SIZE_BITS-1:0]         RESET_FRAME_HEIGHT    = SIZE_BITS'(1024);
   localparam logic signed [COEF_BITS-1:0]  RESET_CENTER_WEIGHT   = COEF_BITS'(16384);
   localparam logic signed [COEF_BITS-1:0]  RESET_NEIGHBOR_WEIGHT = COEF_BITS'(0);
   localparam logic [VALUE_BITS-1:0]        RESET_MAX_VALUE       = VALUE_BITS'(255);

   // kind of an input item
   typedef enum logic {
      ACTION_PIXEL = 1'b0,
      ACTION_DRAIN = 1'b1
   } action_type;

   // decoded work for one accepted item
   typedef struct packed {
      logic                    has_result;
      logic                    do_write;
      logic                    use_pixel;
      logic                    use_up;
      logic                    use_left;
      logic                    use_right;
      logic                    frame_end;
      logic [COL_BITS-1:0]     col;
      logic [OUT_ROW_BITS-1:0] out_row;
   } scan_cmd_type;

   // item held in the read stage
   typedef struct packed {
      scan_cmd_type            cmd;
      logic [PIXEL_BITS-1:0]   pixel;
   } s1_item_type;

   // position tags that travel with a result
   typedef struct packed {
      logic [OUT_ROW_BITS-1:0] row;
      logic [OUT_COL_BITS-1:0] col;
      logic                    frame_end;
   } out_meta_type;

   // frame size limited to 2..hi
   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                       input int hi);
      logic [SIZE_BITS-1:0] r;
      r = v;
      if (v < SIZE_BITS'(2)) begin
         r = SIZE_BITS'(2);
      end else if (v > SIZE_BITS'(hi)) begin
         r = SIZE_BITS'(hi);
      end
      return r;
   endfunction

endpackage

// ===== rtl/five_point_stencil_filter_core.sv =====
// Five-point stencil filter top level. Pixels stream in raster order, one per clock
// while req_stall is low; the result for row r-1 leaves while row r streams in, and
// drain items after the last pixel flush the last row. Sustained rate is one item per
// cycle while rsp_stall stays low: each transfer reads two neighboring columns of
// a 1024 x 32 RAM holding the two previous rows, and each pixel item writes its column
// back as it leaves the read stage. A result passes through the product registers and
// the result register to the rsp_ port. No clearing pass is needed after reset.
module five_point_stencil_filter_core import fpsf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [15:0]               req_pixel_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_pixel_out,
   output logic [9:0]                rsp_out_row,
   output logic [9:0]                rsp_out_col,
   output logic                      rsp_frame_end
);

   logic [SIZE_BITS-1:0]         frame_w_ff;
   logic [SIZE_BITS-1:0]         frame_h_ff;
   logic signed [COEF_BITS-1:0]  center_weight_ff;
   logic signed [COEF_BITS-1:0]  neighbor_weight_ff;
   logic [VALUE_BITS-1:0]        max_value_ff;

   logic                         req_accept;
   scan_cmd_type                 scan_cmd;

   logic                         s1_valid_ff, s1_valid_in;
   s1_item_type                  s1_ff;
   logic                         s1_go;
   logic [PIXEL_BITS-1:0]        prev_center_ff;

   logic [COL_BITS-1:0]          rd_addr_b;
   logic [ROW_WORD_BITS-1:0]     rd_data_a;
   logic [ROW_WORD_BITS-1:0]     rd_data_b;
   logic                         ram_we;

   logic [PIXEL_BITS-1:0]        center;
   logic [PIXEL_BITS-1:0]        upper;
   logic [PIXEL_BITS-1:0]        right;
   logic [NSUM_BITS-1:0]         nsum;
   out_meta_type                 s1_meta;
   out_meta_type                 rsp_meta;
   logic                         mac_stall;

   // configuration registers, frame sizes kept already clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff         <= clamp_size(RESET_FRAME_WIDTH, MAX_WIDTH);
         frame_h_ff         <= clamp_size(RESET_FRAME_HEIGHT, MAX_HEIGHT);
         center_weight_ff   <= RESET_CENTER_WEIGHT;
         neighbor_weight_ff <= RESET_NEIGHBOR_WEIGHT;
         max_value_ff       <= RESET_MAX_VALUE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:     frame_w_ff <= clamp_size(csr_wdata[SIZE_BITS-1:0], MAX_WIDTH);
            CSR_FRAME_HEIGHT:    frame_h_ff <= clamp_size(csr_wdata[SIZE_BITS-1:0], MAX_HEIGHT);
            CSR_CENTER_WEIGHT:   center_weight_ff   <= csr_wdata[COEF_BITS-1:0];
            CSR_NEIGHBOR_WEIGHT: neighbor_weight_ff <= csr_wdata[COEF_BITS-1:0];
            CSR_MAX_VALUE:       max_value_ff       <= csr_wdata[VALUE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // input transfer
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   fpsf_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .action  (action_type'(req_action)),
      .frame_w (frame_w_ff),
      .frame_h (frame_h_ff),
      .cmd     (scan_cmd)
   );

   // line store: {upper, middle} per column
   assign rd_addr_b = scan_cmd.col + COL_BITS'(1);
   assign ram_we    = s1_go && s1_ff.cmd.do_write;

   fpsf_row_ram #(
      .WIDTH (ROW_WORD_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (s1_ff.cmd.col),
      .wr_data   ({center, s1_ff.pixel}),
      .rd_en     (req_accept),
      .rd_addr_a (scan_cmd.col),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // read stage
   assign s1_go       = s1_valid_ff && (!s1_ff.cmd.has_result || !mac_stall);
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff.cmd   <= scan_cmd;
         s1_ff.pixel <= req_pixel_in[PIXEL_BITS-1:0];
      end
   end

   // left neighbor is the center of the previous item in the same row
   always_ff @(posedge clock) begin
      if (s1_go && (s1_ff.cmd.do_write || s1_ff.cmd.has_result)) begin
         prev_center_ff <= center;
      end
   end

   // neighbor sum
   assign center = rd_data_a[PIXEL_BITS-1:0];
   assign upper  = rd_data_a[ROW_WORD_BITS-1:PIXEL_BITS];
   assign right  = rd_data_b[PIXEL_BITS-1:0];

   assign nsum = (s1_ff.cmd.use_pixel ? NSUM_BITS'(s1_ff.pixel)    : '0)
               + (s1_ff.cmd.use_up    ? NSUM_BITS'(upper)          : '0)
               + (s1_ff.cmd.use_left  ? NSUM_BITS'(prev_center_ff) : '0)
               + (s1_ff.cmd.use_right ? NSUM_BITS'(right)          : '0);

   assign s1_meta.row       = s1_ff.cmd.out_row;
   assign s1_meta.col       = OUT_COL_BITS'(s1_ff.cmd.col);
   assign s1_meta.frame_end = s1_ff.cmd.frame_end;

   fpsf_mac u_mac (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s1_valid_ff && s1_ff.cmd.has_result),
      .in_stall        (mac_stall),
      .center          (center),
      .nsum            (nsum),
      .meta            (s1_meta),
      .center_weight   (center_weight_ff),
      .neighbor_weight (neighbor_weight_ff),
      .max_value       (max_value_ff),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .pixel_out       (rsp_pixel_out),
      .meta_out        (rsp_meta)
   );

   assign rsp_out_row   = rsp_meta.row;
   assign rsp_out_col   = rsp_meta.col;
   assign rsp_frame_end = rsp_meta.frame_end;

   // a blocked read stage keeps its item and its column
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && req_stall) |=> (s1_valid_ff && $stable(s1_ff.cmd.col)))
      else $error("read stage lost its item while blocked");

   // the frame's last pixel comes from a drain, which never writes the store
   a_frame_end_no_write : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.cmd.frame_end) |-> (!s1_ff.cmd.do_write && !ram_we))
      else $error("drain item writing the line store");

   // every pixel that yields a result also updates the store on leaving
   a_pixel_writes : assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_ff.cmd.has_result && s1_ff.cmd.use_pixel) |-> ram_we)
      else $error("pixel result without line store update");

endmodule

// ===== rtl/fpsf_row_ram.sv =====
// two-row line store: one write port, two registered read ports with write-through
module fpsf_row_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [WIDTH-1:0]     rd_data_a,
   output logic [WIDTH-1:0]     rd_data_b
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, a same-cycle write to the same entry is passed through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : store_ff[rd_addr_a];
         rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/fpsf_scan.sv =====
// raster position tracking and per-item decode for the stencil filter
module fpsf_scan import fpsf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  action_type           action,
   input  logic [SIZE_BITS-1:0] frame_w,
   input  logic [SIZE_BITS-1:0] frame_h,
   output scan_cmd_type         cmd
);

   logic [ROW_BITS-1:0] in_row_ff, in_row_in;
   logic [COL_BITS-1:0] in_col_ff, in_col_in;
   logic [COL_BITS-1:0] drain_col_ff, drain_col_in;
   logic                draining_ff, draining_in;

   logic col_last;
   logic row_last;
   logic drain_last;

   // end of row, end of frame and end of drain
   assign col_last   = (SIZE_BITS'(in_col_ff) + SIZE_BITS'(1)) >= frame_w;
   assign row_last   = (SIZE_BITS'(in_row_ff) + SIZE_BITS'(1)) >= frame_h;
   assign drain_last = (SIZE_BITS'(drain_col_ff) + SIZE_BITS'(1)) >= frame_w;

   // decode of the item at the port
   always_comb begin
      cmd = '0;
      unique case (action)
         ACTION_PIXEL: begin
            cmd.has_result = !draining_ff && (in_row_ff != '0);
            cmd.do_write   = !draining_ff;
            cmd.use_pixel  = 1'b1;
            cmd.use_up     = in_row_ff >= ROW_BITS'(2);
            cmd.use_left   = in_col_ff != '0;
            cmd.use_right  = !col_last;
            cmd.frame_end  = 1'b0;
            cmd.col        = in_col_ff;
            cmd.out_row    = OUT_ROW_BITS'(in_row_ff - ROW_BITS'(1));
         end
         ACTION_DRAIN: begin
            cmd.has_result = draining_ff;
            cmd.do_write   = 1'b0;
            cmd.use_pixel  = 1'b0;
            cmd.use_up     = 1'b1;
            cmd.use_left   = drain_col_ff != '0;
            cmd.use_right  = !drain_last;
            cmd.frame_end  = drain_last;
            cmd.col        = drain_col_ff;
            cmd.out_row    = OUT_ROW_BITS'(frame_h - SIZE_BITS'(1));
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // position update on each transfer
   always_comb begin
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      drain_col_in = drain_col_ff;
      draining_in  = draining_ff;
      if (accept) begin
         if ((action == ACTION_PIXEL) && !draining_ff) begin
            if (col_last) begin
               in_col_in = '0;
               if (row_last) begin
                  in_row_in    = '0;
                  draining_in  = 1'b1;
                  drain_col_in = '0;
               end else begin
                  in_row_in = in_row_ff + ROW_BITS'(1);
               end
            end else begin
               in_col_in = in_col_ff + COL_BITS'(1);
            end
         end else if ((action == ACTION_DRAIN) && draining_ff) begin
            if (drain_last) begin
               draining_in  = 1'b0;
               drain_col_in = '0;
            end else begin
               drain_col_in = drain_col_ff + COL_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         drain_col_ff <= '0;
         draining_ff  <= 1'b0;
      end else begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         drain_col_ff <= drain_col_in;
         draining_ff  <= draining_in;
      end
   end

endmodule

// ===== rtl/fpsf_mac.sv =====
// weight multiply, rounding and clamping pipeline with the result register
module fpsf_mac import fpsf_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  logic [PIXEL_BITS-1:0]       center,
   input  logic [NSUM_BITS-1:0]        nsum,
   input  out_meta_type                meta,
   input  logic signed [COEF_BITS-1:0] center_weight,
   input  logic signed [COEF_BITS-1:0] neighbor_weight,
   input  logic [VALUE_BITS-1:0]       max_value,
   output logic                        out_valid,
   input  logic                        out_stall,
   output logic [VALUE_BITS-1:0]       pixel_out,
   output out_meta_type                meta_out
);

   logic signed [PIXEL_BITS:0]    center_s;
   logic signed [NSUM_BITS:0]     nsum_s;
   logic signed [PROD_C_BITS-1:0] prod_c_in, prod_c_ff;
   logic signed [PROD_N_BITS-1:0] prod_n_in, prod_n_ff;
   logic                          s2_valid_ff;
   out_meta_type                  s2_meta_ff;

   logic signed [ACC_BITS-1:0]    acc;
   logic [QUOT_BITS-1:0]          quot;
   logic [VALUE_BITS-1:0]         pixel_in;

   logic                          out_valid_ff;
   logic [VALUE_BITS-1:0]         pixel_ff;
   out_meta_type                  out_meta_ff;

   logic                          out_free;
   logic                          s2_go;
   logic                          s2_free;

   // stage flow
   assign out_free = !out_valid_ff || !out_stall;
   assign s2_go    = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || s2_go;
   assign in_stall = !s2_free;

   // products
   assign center_s  = $signed({1'b0, center});
   assign nsum_s    = $signed({1'b0, nsum});
   assign prod_c_in = center_weight * center_s;
   assign prod_n_in = neighbor_weight * nsum_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s2_free) begin
         prod_c_ff  <= prod_c_in;
         prod_n_ff  <= prod_n_in;
         s2_meta_ff <= meta;
      end
   end

   // sum, round half up, clamp to 0..max_value
   assign acc  = ACC_BITS'(prod_c_ff) + ACC_BITS'(prod_n_ff) + ROUND_HALF;
   assign quot = acc[ACC_BITS-2:COEF_FRAC_BITS];

   always_comb begin
      priority if (acc[ACC_BITS-1]) begin
         pixel_in = '0;
      end else if (quot > QUOT_BITS'(max_value)) begin
         pixel_in = max_value;
      end else begin
         pixel_in = quot[VALUE_BITS-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s2_go) begin
         out_valid_ff <= 1'b1;
      end else if (!out_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         pixel_ff    <= pixel_in;
         out_meta_ff <= s2_meta_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign pixel_out = pixel_ff;
   assign meta_out  = out_meta_ff;

endmodule
